@@ rtl/psdm_pkg.sv @@
// shared types and constants for the modular power series divider
`default_nettype none

package psdm_pkg;

    // the prime modulus and its multiples
    localparam logic [29:0] PRIME    = 30'd998244353;
    localparam logic [31:0] PRIME_X1 = 32'd998244353;
    localparam logic [31:0] PRIME_X2 = 32'd1996488706;

    // barrett reciprocal, floor(2^60 / p), fits in 31 bits
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd998244353);

    // item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FEED = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  tap_index;
        logic [29:0] coeff_value;
        logic        is_last;
    } t_in_item;

    typedef struct packed {
        logic [29:0] quotient_coeff;
        logic        coeff_last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_tap;
        logic start_feed;
        logic issue_rd;
        logic finish;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_held;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/psdm_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module psdm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/psdm_ctrl.sv @@
// sequencing state machine and tap count register
`default_nettype none

module psdm_ctrl #(
    parameter int MAX_TAPS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_cmd,
    output logic                        o_in_stall,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [4:0]             i_cfg_data,
    output psdm_pkg::t_ctrl_cmd         o_ctrl,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] o_rd_idx,
    input  psdm_pkg::t_dp_status        i_stat
);

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_k, n_k;
    logic [4:0]    r_tap_count;
    logic [CW-1:0] w_m;
    logic          w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_rd_idx    = r_k[IW-1:0];

    // taps in use, clamped to the storage depth
    assign w_m = (9'(r_tap_count) > 9'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(r_tap_count);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == psdm_pkg::CMD_FEED) begin
                        o_ctrl.start_feed = 1'b1;
                        n_k               = '0;
                        n_state           = S_MAC;
                    end else begin
                        o_ctrl.load_tap = 1'b1;
                    end
                end
            end
            S_MAC: begin
                if (r_k == w_m) begin
                    n_state = S_DRAIN;
                end else begin
                    o_ctrl.issue_rd = 1'b1;
                    n_k             = r_k + CW'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy && !i_stat.out_held) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_tap_count <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/psdm_dp.sv @@
// tap and history stores, modular multiply-accumulate pipeline, output register
`default_nettype none

module psdm_dp #(
    parameter int MAX_TAPS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  psdm_pkg::t_in_item          i_in_item,
    input  psdm_pkg::t_ctrl_cmd         i_ctrl,
    input  wire logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] i_rd_idx,
    output psdm_pkg::t_dp_status        o_stat,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output psdm_pkg::t_out_item         o_out_item
);

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);

    // input reduction
    logic [29:0]         w_in_red;
    logic [8:0]          w_tidx_m1;
    logic                w_tidx_ok;
    logic                w_tap_we;

    // stores
    logic [MAX_TAPS-1:0] r_tap_vld;
    logic [IW-1:0]       r_wp;
    logic [IW-1:0]       r_hp;
    logic [CW-1:0]       r_fill;
    logic [29:0]         w_tap_rd;
    logic [29:0]         w_hist_rd;
    logic [IW-1:0]       w_hist_raddr;

    // feed item
    logic [29:0]         r_val;
    logic                r_last;

    // pipeline
    logic                r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic                r_s1_tok, r_s1_hok;
    logic [59:0]         r_p;
    logic [61:0]         w_q2;
    logic [30:0]         r_q3;
    logic [31:0]         r_x3, r_x4, r_t4;
    logic [31:0]         w_r;
    logic [29:0]         w_r_red, r_r5;
    logic [30:0]         w_acc_sum;
    logic [29:0]         r_acc;

    // result
    logic [30:0]         w_diff;
    logic [29:0]         w_q;

    assign w_in_red  = (i_in_item.coeff_value >= psdm_pkg::PRIME)
                     ? i_in_item.coeff_value - psdm_pkg::PRIME : i_in_item.coeff_value;
    assign w_tidx_m1 = 9'(i_in_item.tap_index) - 9'd1;
    assign w_tidx_ok = (i_in_item.tap_index != 5'd0) &&
                       (9'(i_in_item.tap_index) <= 9'(MAX_TAPS));
    assign w_tap_we  = i_ctrl.load_tap && w_tidx_ok;

    // newest history entry first, walking back through the ring
    assign w_hist_raddr = r_hp;

    psdm_ram #(.WIDTH(30), .DEPTH(MAX_TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (w_tap_we),
        .i_waddr (w_tidx_m1[IW-1:0]),
        .i_wdata (w_in_red),
        .i_raddr (i_rd_idx),
        .o_rdata (w_tap_rd)
    );

    psdm_ram #(.WIDTH(30), .DEPTH(MAX_TAPS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.finish),
        .i_waddr (r_wp),
        .i_wdata (w_q),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_rd)
    );

    // barrett estimate and remainder correction
    assign w_q2      = 62'(r_p[59:29]) * 62'(psdm_pkg::BARRETT_MU);
    assign w_r       = r_x4 - r_t4;
    assign w_r_red   = (w_r >= psdm_pkg::PRIME_X2) ? 30'(w_r - psdm_pkg::PRIME_X2)
                     : (w_r >= psdm_pkg::PRIME_X1) ? 30'(w_r - psdm_pkg::PRIME_X1)
                     : w_r[29:0];
    assign w_acc_sum = 31'(r_acc) + 31'(r_r5);

    // q = val - acc mod p
    assign w_diff = 31'(r_val) - 31'(r_acc);
    assign w_q    = w_diff[30] ? 30'(w_diff + 31'(psdm_pkg::PRIME)) : w_diff[29:0];

    assign o_stat.pipe_busy = r_s1_v || r_s2_v || r_s3_v || r_s4_v || r_s5_v;
    assign o_stat.out_held  = o_out_valid && i_out_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_vld   <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_s5_v      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_tap_we) begin
                r_tap_vld[w_tidx_m1[IW-1:0]] <= 1'b1;
            end
            r_s1_v <= i_ctrl.issue_rd;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            if (i_ctrl.finish) begin
                r_wp <= (r_wp == IW'(MAX_TAPS - 1)) ? '0 : r_wp + IW'(1);
                if (r_last) begin
                    r_fill <= '0;
                end else if (r_fill != CW'(MAX_TAPS)) begin
                    r_fill <= r_fill + CW'(1);
                end
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start_feed) begin
            r_val <= w_in_red;
            r_last <= i_in_item.is_last;
            r_acc <= '0;
            r_hp  <= (r_wp == '0) ? IW'(MAX_TAPS - 1) : r_wp - IW'(1);
        end else begin
            if (i_ctrl.issue_rd) begin
                r_hp <= (r_hp == '0) ? IW'(MAX_TAPS - 1) : r_hp - IW'(1);
            end
            if (r_s5_v) begin
                r_acc <= (w_acc_sum >= 31'(psdm_pkg::PRIME))
                       ? 30'(w_acc_sum - 31'(psdm_pkg::PRIME)) : w_acc_sum[29:0];
            end
        end
        // unwritten taps and history older than the series read as zero
        r_s1_tok <= r_tap_vld[i_rd_idx];
        r_s1_hok <= (CW'(i_rd_idx) < r_fill);
        r_p      <= 60'(r_s1_tok ? w_tap_rd : 30'd0) * 60'(r_s1_hok ? w_hist_rd : 30'd0);
        r_q3     <= w_q2[61:31];
        r_x3     <= r_p[31:0];
        r_t4     <= 32'(r_q3) * psdm_pkg::PRIME_X1;
        r_x4     <= r_x3;
        r_r5     <= w_r_red;
        if (i_ctrl.finish) begin
            o_out_item.quotient_coeff <= w_q;
            o_out_item.coeff_last     <= r_last;
        end
    end

endmodule

`default_nettype wire

@@ rtl/power_series_divide_mod_p.sv @@
// top level of the power series divider modulo 998244353
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_item) carries load and feed items;
//   a transfer happens on a rising edge with valid high and stall low
//   load items write denominator tap 1..MAX_TAPS and give no result
//   feed items give one quotient coefficient each on the output channel
//   (o_out_valid / i_out_stall / o_out_item), in arrival order
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes tap_count; ready is
//   always high; writes are to be made only while the block is idle, a rule the user must keep
// timing:
//   a feed item's result is registered after all m products are accumulated, m being the
//   taps in use (tap_count clamped to MAX_TAPS); one shared multiply and barrett reduction
//   pipeline takes one tap per cycle and the input stalls until the result is registered,
//   so a new feed item is taken only after the last one's result is registered
// reset:
//   synchronous active low; clears tap count, tap and history fill state, output valid
// output stall:
//   the finished result waits in the output register; a load item or the next feed item
//   is still taken, and a feed item holds before writing its result until the old one goes
`default_nettype none

module power_series_divide_mod_p #(
    parameter int MAX_TAPS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  psdm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output psdm_pkg::t_out_item o_out_item,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [4:0]     i_cfg_data
);

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    // controller and datapath handshake
    psdm_pkg::t_ctrl_cmd  w_ctrl;
    psdm_pkg::t_dp_status w_stat;
    logic [IW-1:0]        w_rd_idx;

    psdm_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_item.cmd),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_ctrl      (w_ctrl),
        .o_rd_idx    (w_rd_idx),
        .i_stat      (w_stat)
    );

    psdm_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_ctrl      (w_ctrl),
        .i_rd_idx    (w_rd_idx),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // a feed only starts on a real feed transfer
    a_start_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.start_feed |-> (i_in_valid && !o_in_stall &&
                               i_in_item.cmd == psdm_pkg::CMD_FEED))
        else $error("feed started without a feed transfer");

    // result is written only once every product has reached the accumulator
    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.finish |-> !w_stat.pipe_busy)
        else $error("result taken with products still in flight");

    // a waiting result is never overwritten
    a_finish_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.finish |-> !(o_out_valid && i_out_stall))
        else $error("stalled result overwritten");

    // tap reads only happen while the input is held off
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.issue_rd |-> o_in_stall)
        else $error("tap read while idle");

endmodule

`default_nettype wire
